[rtl/lobm_pkg.sv]
// Shared constants and result codes for the limit order book matcher.
// No dependencies.
package lobm_pkg;
    localparam int BOOK_DEPTH_DEF = 32;
    localparam int PRICE_BITS_DEF = 32;
    localparam int QTY_BITS_DEF   = 32;

    localparam logic [1:0] KIND_TRADE = 2'd0;
    localparam logic [1:0] KIND_REST  = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;
endpackage

[rtl/lobm_if.sv]
// Handshake channels of the order book matcher: incoming orders and results.
// No dependencies.
interface lobm_in_if;
    logic        valid;
    logic        ready;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [15:0] trader;
    modport source (output valid, side, limit_price, quantity, trader, input ready);
    modport sink   (input valid, side, limit_price, quantity, trader, output ready);
endinterface

interface lobm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] incoming_trader;
    logic [15:0] resting_trader;
    logic [31:0] fill_quantity;
    logic [31:0] resting_price;
    logic        incoming_full;
    logic        resting_full;
    logic        last;
    modport source (output valid, kind, incoming_trader, resting_trader, fill_quantity,
                    resting_price, incoming_full, resting_full, last, input ready);
    modport sink   (input valid, kind, incoming_trader, resting_trader, fill_quantity,
                    resting_price, incoming_full, resting_full, last, output ready);
endinterface

[rtl/limit_order_book_matcher.sv]
// Price-time priority limit order book matcher, top level.
// Depends on lobm_pkg and the channel interfaces in lobm_if.sv.
//
// Usage: orders enter on i_ord (side, limit price, quantity, trader); results
// leave on o_res, one per transfer. Each order yields one trade result per
// fill against the opposite book, then at most one rest or drop result; the
// final result of an order carries last. A zero-quantity order is taken and
// yields nothing.
// Timing: one sequencer with a single compare unit scans the opposite book
// one slot per cycle, through a registered book read, to find its best order.
// Each result takes a scan of every slot, a decision step and an output
// step; all results of an order (its fills, plus one if a remainder rests
// or drops) are given before the next order is taken.
// i_ord.ready is high only while the block is idle.
// Reset: synchronous, active low; both books become empty and the sequence
// counter returns to zero. No clearing pass is needed.
// Stall: a result is held on o_res until taken; the sequencer waits with it.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int BOOK_DEPTH = BOOK_DEPTH_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int QTY_BITS   = QTY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lobm_in_if.sink       i_ord,
    lobm_out_if.source    o_res
);
    localparam int IDX_BITS = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(BOOK_DEPTH + 1);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(BOOK_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] MAX_FILLS = CNT_BITS'(BOOK_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_OUT} t_state;

    // book 0 bids, book 1 asks
    logic [PRICE_BITS-1:0] r_bk_px  [2][BOOK_DEPTH];
    logic [QTY_BITS-1:0]   r_bk_qty [2][BOOK_DEPTH];
    logic [15:0]           r_bk_tr  [2][BOOK_DEPTH];
    logic [31:0]           r_bk_seq [2][BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] r_bk_vld [2];

    t_state                r_state;
    logic                  r_side;
    logic [PRICE_BITS-1:0] r_limit;
    logic [QTY_BITS-1:0]   r_rem;
    logic [15:0]           r_tr;
    logic [CNT_BITS-1:0]   r_k;
    logic [31:0]           r_seqc;
    logic [IDX_BITS-1:0]   r_idx;
    logic                  r_found;
    logic [IDX_BITS-1:0]   r_bidx;
    logic [PRICE_BITS-1:0] r_bpx;
    logic [QTY_BITS-1:0]   r_bqty;
    logic [15:0]           r_btr;
    logic [31:0]           r_bseq;
    logic                  r_ffound;
    logic [IDX_BITS-1:0]   r_fidx;

    logic [PRICE_BITS-1:0] r_rd_px;
    logic [QTY_BITS-1:0]   r_rd_qty;
    logic [15:0]           r_rd_tr;
    logic [31:0]           r_rd_seq;
    logic                  r_rd_vld;
    logic                  r_rd_fvld;
    logic [IDX_BITS-1:0]   r_rd_idx;
    logic                  r_rd_ok;
    logic                  r_scan_end;

    logic [1:0]            r_kind;
    logic [15:0]           r_rtr;
    logic [QTY_BITS-1:0]   r_fq;
    logic [PRICE_BITS-1:0] r_opx;
    logic                  r_inf;
    logic                  r_rsf;
    logic                  r_last;

    logic                  w_opp;
    logic                  w_better;
    logic                  w_cross;
    logic                  w_in_full;
    logic                  w_rs_full;
    logic [QTY_BITS-1:0]   w_fill;
    logic [QTY_BITS-1:0]   w_in_qty;

    assign w_opp    = ~r_side;
    assign w_in_qty = QTY_BITS'(i_ord.quantity);

    // book read port: registered, data for slot r_idx arrives in the next cycle
    always_ff @(posedge i_clk) begin
        r_rd_px   <= r_bk_px[w_opp][r_idx];
        r_rd_qty  <= r_bk_qty[w_opp][r_idx];
        r_rd_tr   <= r_bk_tr[w_opp][r_idx];
        r_rd_seq  <= r_bk_seq[w_opp][r_idx];
        r_rd_vld  <= r_bk_vld[w_opp][r_idx];
        r_rd_fvld <= r_bk_vld[r_side][r_idx];
        r_rd_idx  <= r_idx;
    end

    always_comb begin
        if (!r_found) begin
            w_better = 1'b1;
        end else if (r_rd_px != r_bpx) begin
            w_better = r_side ? (r_rd_px > r_bpx) : (r_rd_px < r_bpx);
        end else begin
            w_better = r_rd_seq < r_bseq;
        end
    end

    assign w_cross   = r_found && (r_k < MAX_FILLS)
                       && (r_side ? (r_limit <= r_bpx) : (r_limit >= r_bpx));
    assign w_in_full = r_rem <= r_bqty;
    assign w_rs_full = r_bqty <= r_rem;
    assign w_fill    = w_in_full ? r_rem : r_bqty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bk_vld[0] <= '0;
            r_bk_vld[1] <= '0;
            r_seqc      <= '0;
            r_k         <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_ffound    <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_scan_end  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ord.valid && (w_in_qty != '0)) begin
                        r_side     <= i_ord.side;
                        r_limit    <= PRICE_BITS'(i_ord.limit_price);
                        r_rem      <= w_in_qty;
                        r_tr       <= i_ord.trader;
                        r_k        <= '0;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_ffound   <= 1'b0;
                        r_rd_ok    <= 1'b0;
                        r_scan_end <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_ok && r_rd_vld && w_better) begin
                        r_found <= 1'b1;
                        r_bidx  <= r_rd_idx;
                        r_bpx   <= r_rd_px;
                        r_bqty  <= r_rd_qty;
                        r_btr   <= r_rd_tr;
                        r_bseq  <= r_rd_seq;
                    end
                    if (r_rd_ok && !r_ffound && !r_rd_fvld) begin
                        r_ffound <= 1'b1;
                        r_fidx   <= r_rd_idx;
                    end
                    r_rd_ok <= !r_scan_end;
                    if (!r_scan_end) begin
                        if (r_idx == LAST_IDX) begin
                            r_scan_end <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    if (r_rd_ok && (r_rd_idx == LAST_IDX)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_OUT;
                    if (w_cross) begin
                        r_kind <= KIND_TRADE;
                        r_rtr  <= r_btr;
                        r_fq   <= w_fill;
                        r_opx  <= r_bpx;
                        r_inf  <= w_in_full;
                        r_rsf  <= w_rs_full;
                        r_last <= w_in_full;
                        r_rem  <= r_rem - w_fill;
                        r_k    <= r_k + 1'b1;
                        if (w_rs_full) begin
                            r_bk_vld[w_opp][r_bidx] <= 1'b0;
                        end else begin
                            r_bk_qty[w_opp][r_bidx] <= r_bqty - w_fill;
                        end
                    end else begin
                        r_rtr  <= '0;
                        r_fq   <= r_rem;
                        r_opx  <= r_limit;
                        r_inf  <= 1'b0;
                        r_rsf  <= 1'b0;
                        r_last <= 1'b1;
                        if (r_ffound) begin
                            r_kind                   <= KIND_REST;
                            r_seqc                   <= r_seqc + 1'b1;
                            r_bk_px[r_side][r_fidx]  <= r_limit;
                            r_bk_qty[r_side][r_fidx] <= r_rem;
                            r_bk_tr[r_side][r_fidx]  <= r_tr;
                            r_bk_seq[r_side][r_fidx] <= r_seqc + 1'b1;
                            r_bk_vld[r_side][r_fidx] <= 1'b1;
                        end else begin
                            r_kind <= KIND_DROP;
                        end
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx      <= '0;
                            r_found    <= 1'b0;
                            r_ffound   <= 1'b0;
                            r_rd_ok    <= 1'b0;
                            r_scan_end <= 1'b0;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_ord.ready           = (r_state == S_IDLE);
    assign o_res.valid           = (r_state == S_OUT);
    assign o_res.kind            = r_kind;
    assign o_res.incoming_trader = r_tr;
    assign o_res.resting_trader  = r_rtr;
    assign o_res.fill_quantity   = 32'(r_fq);
    assign o_res.resting_price   = 32'(r_opx);
    assign o_res.incoming_full   = r_inf;
    assign o_res.resting_full    = r_rsf;
    assign o_res.last            = r_last;

    a_nontrade_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.kind != KIND_TRADE) |-> o_res.last)
        else $error("rest or drop result without last");
    a_trade_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.kind == KIND_TRADE) |-> (o_res.last == o_res.incoming_full))
        else $error("trade last disagrees with incoming fill");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ord.ready && o_res.valid))
        else $error("order taken while a result is pending");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= MAX_FILLS)
        else $error("fill count beyond book depth");
endmodule

[test/tb_limit_order_book_matcher.sv]
// Testbench for limit_order_book_matcher: drives orders on i_ord, predicts fills,
// rests and drops with a behavioural order book, and checks every o_res transfer.
// Depends on lobm_pkg, lobm_if.sv and the RTL top level.
module tb_limit_order_book_matcher
    import lobm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] in_tr;
        logic [15:0] rest_tr;
        logic [31:0] qty;
        logic [31:0] px;
        logic        in_full;
        logic        rest_full;
        logic        last;
    } result_t;

    typedef struct {
        logic [31:0] px;
        logic [31:0] qty;
        logic [15:0] tr;
        logic [31:0] seq;
        bit          valid;
    } entry_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    lobm_in_if  ord_ch();
    lobm_out_if res_ch();

    limit_order_book_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ord(ord_ch.sink), .o_res(res_ch.source)
    );

    always #10 i_clk = ~i_clk;

    entry_t      bids[DEPTH];
    entry_t      asks[DEPTH];
    logic [31:0] seq_count;
    result_t     pending_results[$];
    int          errors = 0;
    int          n_orders = 0;
    int          n_results = 0;
    int          n_trades = 0;
    int          n_drops = 0;
    int          idle_cycles = 0;

    initial begin
        ord_ch.valid = 1'b0;
        ord_ch.side = 1'b0;
        ord_ch.limit_price = '0;
        ord_ch.quantity = '0;
        ord_ch.trader = '0;
        res_ch.ready = 1'b0;
    end

    function automatic int best_of(bit bid_book);
        int b;
        entry_t e;
        entry_t x;
        b = -1;
        for (int i = 0; i < DEPTH; i++) begin
            e = bid_book ? bids[i] : asks[i];
            if (!e.valid) continue;
            if (b < 0) begin
                b = i;
            end else begin
                x = bid_book ? bids[b] : asks[b];
                if (e.px != x.px) begin
                    if (bid_book ? (e.px > x.px) : (e.px < x.px)) b = i;
                end else if (e.seq < x.seq) begin
                    b = i;
                end
            end
        end
        return b;
    endfunction

    function automatic void match_order(bit sell, logic [31:0] lim, logic [31:0] q,
                                        logic [15:0] tr);
        logic [31:0] rem;
        logic [31:0] fill;
        int          k;
        int          b;
        int          slot;
        entry_t      e;
        result_t     r;
        rem = q;
        k = 0;
        slot = -1;
        if (rem == 0) return;
        while (rem != 0 && k < DEPTH) begin
            b = best_of(sell);
            if (b < 0) break;
            e = sell ? bids[b] : asks[b];
            if (sell ? (lim > e.px) : (lim < e.px)) break;
            fill = (rem < e.qty) ? rem : e.qty;
            r = '{KIND_TRADE, tr, e.tr, fill, e.px, fill == rem, fill == e.qty, fill == rem};
            pending_results.push_back(r);
            n_trades++;
            k++;
            rem -= fill;
            if (fill == e.qty) e.valid = 0;
            else e.qty -= fill;
            if (sell) bids[b] = e;
            else asks[b] = e;
        end
        if (rem == 0) return;
        for (int i = 0; i < DEPTH; i++) begin
            e = sell ? asks[i] : bids[i];
            if (!e.valid) begin
                slot = i;
                break;
            end
        end
        if (slot < 0) begin
            pending_results.push_back('{KIND_DROP, tr, 16'd0, rem, lim, 1'b0, 1'b0, 1'b1});
            n_drops++;
            return;
        end
        seq_count++;
        e = '{lim, rem, tr, seq_count, 1'b1};
        if (sell) asks[slot] = e;
        else bids[slot] = e;
        pending_results.push_back('{KIND_REST, tr, 16'd0, rem, lim, 1'b0, 1'b0, 1'b1});
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_order(bit sell, logic [31:0] lim, logic [31:0] q, logic [15:0] tr);
        int g;
        ord_ch.valid <= 1'b1;
        ord_ch.side <= sell;
        ord_ch.limit_price <= lim;
        ord_ch.quantity <= q;
        ord_ch.trader <= tr;
        do @(posedge i_clk); while (!ord_ch.ready);
        match_order(sell, lim, q, tr);
        n_orders++;
        g = gap_len();
        if (g > 0) begin
            ord_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        ord_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5 * (DEPTH + 2)) @(posedge i_clk);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        result_t got;
        result_t exp;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.kind, res_ch.incoming_trader, res_ch.resting_trader,
                    res_ch.fill_quantity, res_ch.resting_price, res_ch.incoming_full,
                    res_ch.resting_full, res_ch.last};
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
            end else begin
                exp = pending_results.pop_front();
                if (got !== exp) begin
                    $display("%0t mismatch: expected %p actual %p", $time, exp, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) stall = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((ord_ch.valid && ord_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("[limit_order_book_matcher] ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        send_order(1'b0, 32'd100, 32'd0, 16'h0001);
        send_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_order(1'b0, 32'd0, 32'd1, 16'h0000);
        send_order(1'b0, 32'hFFFF_FFFF, 32'd5, 16'h0002);
        send_order(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0003);
        send_order(1'b1, 32'd0, 32'd7, 16'h0004);
        send_order(1'b1, 32'd50, 32'd10, 16'h0005);
        send_order(1'b1, 32'd50, 32'd10, 16'h0006);
        send_order(1'b1, 32'd40, 32'd3, 16'h0007);
        send_order(1'b0, 32'd50, 32'd15, 16'h0008);
        send_order(1'b0, 32'd60, 32'd20, 16'h0009);
        drain();
    endtask

    task automatic test_book_full();
        for (int i = 0; i < DEPTH + 2; i++)
            send_order(1'b1, 32'd1000 + i, 32'd1 + i, 16'(32'h0100 + i));
        send_order(1'b0, 32'd1100, 32'd100000, 16'h0200);
        for (int i = 0; i < DEPTH + 2; i++)
            send_order(1'b0, 32'd10, 32'd2, 16'(32'h0300 + i));
        send_order(1'b1, 32'd5, 32'hFFFF_FFFF, 16'h0400);
        drain();
    endtask

    task automatic test_random(int count);
        logic [31:0] mid;
        logic [31:0] lim;
        logic [31:0] q;
        int p;
        mid = 32'd5000;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(0, 99);
            if (p < 80) begin
                lim = mid + $urandom_range(0, 20) - 10;
                q = $urandom_range(1, 60);
            end else if (p < 95) begin
                lim = $urandom;
                q = $urandom;
            end else begin
                lim = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                q = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
            end
            send_order(1'($urandom_range(0, 1)), lim, q, 16'($urandom));
            if (n == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            bids[i] = '{default: '0};
            asks[i] = '{default: '0};
        end
        seq_count = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_book_full();
        test_random(400);
        $display("Covered %0d orders, %0d results (%0d fills, %0d drops)",
                 n_orders, n_results, n_trades, n_drops);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[limit_order_book_matcher] OK");
        end else begin
            $display("[limit_order_book_matcher] ERROR");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/lobm_pkg.sv
rtl/lobm_if.sv
rtl/limit_order_book_matcher.sv
test/tb_limit_order_book_matcher.sv
